// File: hw/rtl/at2d_pkg.sv
// ----------------------------------------------------------------------------
// at2d_pkg
// Types, constants and tables shared by the 2D affine transform engine.
// ----------------------------------------------------------------------------
`default_nettype none
package at2d_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_FRAC     = 24;
  localparam int CORDIC_FRAC  = 30;

  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    CMD_IDENTITY = 3'd0,
    CMD_SCALE    = 3'd1,
    CMD_SHIFT    = 3'd2,
    CMD_ROTATE   = 3'd3,
    CMD_GAIN     = 3'd4,
    CMD_POINT    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CORDIC,
    ST_MUL,
    ST_WRITE,
    ST_OUT
  } state_t;

  // atan(2^-i) in degrees, Q.24
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'(SAT_MAX)) r = SAT_MAX;
    else if (v < 36'(SAT_MIN)) r = SAT_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/at2d_if.sv
// ----------------------------------------------------------------------------
// at2d_in_if / at2d_out_if
// Valid/ready channels of the transform engine.
// ----------------------------------------------------------------------------
`default_nettype none
interface at2d_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] factor_x;
  logic signed [31:0] factor_y;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [25:0] angle_degrees;
  logic signed [31:0] gain;
  modport source (output valid, command, point_x, point_y, factor_x, factor_y,
                  offset_x, offset_y, angle_degrees, gain, input ready);
  modport sink (input valid, command, point_x, point_y, factor_x, factor_y,
                offset_x, offset_y, angle_degrees, gain, output ready);
endinterface

interface at2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  modport source (output valid, result_x, result_y, input ready);
  modport sink (input valid, result_x, result_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/affine_transform_2d_engine.sv
// ----------------------------------------------------------------------------
// affine_transform_2d_engine
// 3x3 homogeneous 2D transform in Q16.16 with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Sequence: identity and unused codes take effect at the accepting edge; scale
//   and shift hold in_ready low for 27 products and the write-back, gain for its
//   products and write-back, rotate for reduce, 16 CORDIC steps, 27 products, write-back.
// Point: four products, then a hand-off into the output register;
//   the hand-off waits while a previous result is still held off.
// Reset: synchronous active-low rst_n restores the identity matrix and idles.
`default_nettype none
module affine_transform_2d_engine
  import at2d_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  at2d_in_if.sink    in_ch,
  at2d_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic signed [31:0] m_r [9];     // current matrix, row major
  logic signed [31:0] r_r [9];     // new matrix being built
  logic signed [31:0] t_r [9];     // command matrix T
  logic [2:0]         cmd_r;
  logic signed [31:0] px_r, py_r;

  // iteration counters: output entry (i,j) and term k
  logic [1:0] i_r, j_r, k_r;
  logic signed [35:0] acc_r;

  // CORDIC state
  logic signed [33:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic               neg_r;
  logic [4:0]         it_r;

  // finished point, parked until the output register is free
  logic signed [31:0] pt_x_r, pt_y_r;
  logic signed [31:0] res_x_r, res_y_r;
  logic               out_valid_r;
  logic               out_load;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.result_x = res_x_r;
  assign out_ch.result_y = res_y_r;

  // hand-off into the output register when it is empty or being drained
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  wire accept = in_ch.valid && in_ch.ready;

  // ---------------- shared multiply / round / saturate unit ----------------
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [64:0] prod_rnd;
  logic signed [31:0] mul_q;
  logic [3:0]         t_idx, m_idx;

  always_comb begin
    t_idx = 4'(i_r) * 4'd3 + 4'(k_r);
    m_idx = 4'(k_r) * 4'd3 + 4'(j_r);
    case (cmd_r)
      CMD_GAIN: begin
        mul_a = m_r[4'(i_r) * 4'd3 + 4'(j_r)];
        mul_b = t_r[0];
      end
      CMD_POINT: begin
        mul_a = m_r[4'(i_r) * 4'd3 + 4'(k_r)];
        mul_b = (k_r == 2'd0) ? px_r : py_r;
      end
      default: begin
        mul_a = t_r[t_idx];
        mul_b = m_r[m_idx];
      end
    endcase
    prod     = mul_a * mul_b;
    prod_rnd = 65'(prod) + (65'sd1 <<< (FRAC_BITS - 1));
    if ((prod_rnd >>> FRAC_BITS) > 65'(SAT_MAX)) mul_q = SAT_MAX;
    else if ((prod_rnd >>> FRAC_BITS) < 65'(SAT_MIN)) mul_q = SAT_MIN;
    else mul_q = prod_rnd[FRAC_BITS +: 32];
  end

  // ---------------- angle reduction (combinational, constant modulus) ------
  localparam logic signed [35:0] FULL    = 36'sd360 <<< ANG_FRAC;
  localparam logic signed [35:0] HALF    = 36'sd180 <<< ANG_FRAC;
  localparam logic signed [35:0] QUARTER = 36'sd90 <<< ANG_FRAC;
  logic signed [35:0] z0, z1;
  logic               fold;
  always_comb begin
    z0 = 36'(t_r[1]) <<< (ANG_FRAC - FRAC_BITS);
    // |angle| < 2*360: at most one correction each side, C-style remainder
    if (z0 >= FULL) z0 = z0 - FULL;
    else if (z0 <= -FULL) z0 = z0 + FULL;
    if (z0 >= HALF) z0 = z0 - FULL;
    if (z0 < -HALF) z0 = z0 + FULL;
    fold = 1'b0;
    z1 = z0;
    if (z0 > QUARTER) begin
      z1 = z0 - HALF;
      fold = 1'b1;
    end else if (z0 < -QUARTER) begin
      z1 = z0 + HALF;
      fold = 1'b1;
    end
  end

  // CORDIC rounding to FRAC_BITS
  localparam int CSH = CORDIC_FRAC - FRAC_BITS;

  // last CORDIC iteration folded with the output rounding
  function automatic logic signed [33:0] cos_v_next(
    input logic signed [33:0] x, input logic signed [33:0] y,
    input logic signed [31:0] z, input logic [4:0] sh,
    input logic ng, input logic want_sin);
    logic signed [33:0] nx, ny, rx, ry, v;
    if (!z[31]) begin
      nx = x - (y >>> sh);
      ny = y + (x >>> sh);
    end else begin
      nx = x + (y >>> sh);
      ny = y - (x >>> sh);
    end
    rx = (nx + (34'sd1 <<< (CSH - 1))) >>> CSH;
    ry = (ny + (34'sd1 <<< (CSH - 1))) >>> CSH;
    v  = want_sin ? ry : rx;
    if (ng) v = -v;
    return v;
  endfunction

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            CMD_SCALE, CMD_SHIFT, CMD_GAIN, CMD_POINT: state_nxt = ST_MUL;
            CMD_ROTATE: state_nxt = ST_REDUCE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_REDUCE: state_nxt = ST_CORDIC;
      ST_CORDIC: if (it_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_MUL;
      ST_MUL: begin
        case (cmd_r)
          CMD_GAIN:
            if (i_r == 2'd2 && j_r == 2'd2) state_nxt = ST_WRITE;
          CMD_POINT:
            if (i_r == 2'd1 && k_r == 2'd1) state_nxt = ST_OUT;
          default:
            if (i_r == 2'd2 && j_r == 2'd2 && k_r == 2'd2) state_nxt = ST_WRITE;
        endcase
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int n = 0; n < 9; n++) m_r[n] <= (n % 4 == 0) ? ONE : 32'sd0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          i_r   <= 2'd0;
          j_r   <= 2'd0;
          k_r   <= 2'd0;
          acc_r <= '0;
          it_r  <= '0;
          if (accept) begin
            cmd_r <= in_ch.command;
            px_r  <= in_ch.point_x;
            py_r  <= in_ch.point_y;
            for (int n = 0; n < 9; n++) t_r[n] <= (n % 4 == 0) ? ONE : 32'sd0;
            case (in_ch.command)
              CMD_IDENTITY:
                for (int n = 0; n < 9; n++) m_r[n] <= (n % 4 == 0) ? ONE : 32'sd0;
              CMD_SCALE: begin
                t_r[0] <= in_ch.factor_x;
                t_r[4] <= in_ch.factor_y;
              end
              CMD_SHIFT: begin
                t_r[2] <= in_ch.offset_x;
                t_r[5] <= in_ch.offset_y;
              end
              CMD_ROTATE: t_r[1] <= 32'(in_ch.angle_degrees);
              CMD_GAIN:   t_r[0] <= in_ch.gain;
              default: ;
            endcase
          end
        end
        ST_REDUCE: begin
          cx_r  <= CORDIC_K;
          cy_r  <= '0;
          cz_r  <= z1[31:0];
          neg_r <= fold;
        end
        ST_CORDIC: begin
          if (!cz_r[31]) begin
            cx_r <= cx_r - (cy_r >>> it_r);
            cy_r <= cy_r + (cx_r >>> it_r);
            cz_r <= cz_r - $signed({2'b00, atan_deg(it_r)});
          end else begin
            cx_r <= cx_r + (cy_r >>> it_r);
            cy_r <= cy_r - (cx_r >>> it_r);
            cz_r <= cz_r + $signed({2'b00, atan_deg(it_r)});
          end
          it_r <= it_r + 5'd1;
          if (it_r == 5'(CORDIC_STEPS - 1)) begin
            t_r[0] <= 32'(cos_v_next(cx_r, cy_r, cz_r, it_r, neg_r, 1'b0));
            t_r[4] <= 32'(cos_v_next(cx_r, cy_r, cz_r, it_r, neg_r, 1'b0));
            t_r[3] <= 32'(cos_v_next(cx_r, cy_r, cz_r, it_r, neg_r, 1'b1));
            t_r[1] <= -32'(cos_v_next(cx_r, cy_r, cz_r, it_r, neg_r, 1'b1));
          end
        end
        ST_MUL: begin
          case (cmd_r)
            CMD_GAIN: begin
              r_r[4'(i_r) * 4'd3 + 4'(j_r)] <= mul_q;
              if (j_r == 2'd2) begin
                j_r <= 2'd0;
                i_r <= i_r + 2'd1;
              end else j_r <= j_r + 2'd1;
            end
            CMD_POINT: begin
              if (k_r == 2'd1) begin
                if (i_r == 2'd0)
                  pt_x_r <= sat32(acc_r + 36'(mul_q) + 36'(m_r[2]));
                else
                  pt_y_r <= sat32(acc_r + 36'(mul_q) + 36'(m_r[5]));
                acc_r <= '0;
                k_r   <= 2'd0;
                i_r   <= i_r + 2'd1;
              end else begin
                acc_r <= 36'(mul_q);
                k_r   <= k_r + 2'd1;
              end
            end
            default: begin
              if (k_r == 2'd2) begin
                r_r[4'(i_r) * 4'd3 + 4'(j_r)] <= sat32(acc_r + 36'(mul_q));
                acc_r <= '0;
                k_r   <= 2'd0;
                if (j_r == 2'd2) begin
                  j_r <= 2'd0;
                  i_r <= i_r + 2'd1;
                end else j_r <= j_r + 2'd1;
              end else begin
                acc_r <= acc_r + 36'(mul_q);
                k_r   <= k_r + 2'd1;
              end
            end
          endcase
        end
        ST_WRITE: for (int n = 0; n < 9; n++) m_r[n] <= r_r[n];
        ST_OUT: begin
          if (out_load) begin
            res_x_r <= pt_x_r;
            res_y_r <= pt_y_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/at2d_checker.sv
// ----------------------------------------------------------------------------
// at2d_checker
// Port-level checks of the transform engine, bound into affine_transform_2d_engine.
// ----------------------------------------------------------------------------
`default_nettype none
module at2d_checker
  import at2d_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire [2:0]  in_command,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_result_x
);

  // commands that run the sequencer
  wire busy_cmd = (in_command == CMD_SCALE) || (in_command == CMD_SHIFT) ||
                  (in_command == CMD_ROTATE) || (in_command == CMD_GAIN) ||
                  (in_command == CMD_POINT);

  // an accepted word holds off the next one
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && busy_cmd) |=> !in_ready)
    else $error("accepted during work");

  // identity and unused codes finish at once
  a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !busy_cmd) |=> in_ready)
    else $error("quick command stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_x)))
    else $error("result dropped");

  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_ready, out_valid}))
    else $error("handshake unknown");

endmodule

bind affine_transform_2d_engine at2d_checker u_at2d_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_command   (in_ch.command),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_result_x (out_ch.result_x)
);
`default_nettype wire
